/* rtl/hsvrgbw_pkg.sv */
package hsvrgbw_pkg;

    // One colour word in: hue as a fraction of a turn, saturation and value as x/255
    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } t_hsv_word;

    // One colour word out
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } t_rgbw_word;

    localparam logic [7:0] C_LEVEL_MAX = 8'd255;

endpackage

/* rtl/hsv_to_rgbw_converter_core.sv */
// Channel   | Direction | Handshake            | Word
// ----------+-----------+----------------------+--------------------------------
// input     | in        | i_valid / o_stall    | i_data : hsvrgbw_pkg::t_hsv_word
// output    | out       | o_valid / i_stall    | o_data : hsvrgbw_pkg::t_rgbw_word
// config    | in        | i_cfg_we             | i_cfg_wdata : white_mode
//
// One word per cycle sustained while i_stall is low; the accepting edge loads
// the first of five register stages (sector split, chroma products, level
// products, divide by 255 and sector select, white extraction); o_valid is the last.
// Synchronous active-low reset clears every stage valid bit and white_mode.
// Each stage holds only while it is full and the stage after it is held, so
// bubbles close up and a held output stops the front only once all are full.
module hsv_to_rgbw_converter_core #(
    parameter int HUE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  hsvrgbw_pkg::t_hsv_word  i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output hsvrgbw_pkg::t_rgbw_word o_data,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata
);

    localparam int HW = HUE_BITS;

    // Sector codes of the hue circle
    localparam logic [2:0] SECT_RED_YEL = 3'd0;
    localparam logic [2:0] SECT_YEL_GRN = 3'd1;
    localparam logic [2:0] SECT_GRN_CYN = 3'd2;
    localparam logic [2:0] SECT_CYN_BLU = 3'd3;
    localparam logic [2:0] SECT_BLU_MAG = 3'd4;

    // Exact truncating x/255 for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    // Configuration: white extraction on or off
    logic r_white_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_white_mode <= i_cfg_wdata;
        end
    end

    // Stage enables: a stage loads when empty or when the next one moves
    logic en1, en2, en3, en4, en5;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld;

    assign en5     = !r_out_vld || !i_stall;
    assign en4     = !r_s4_vld  || en5;
    assign en3     = !r_s3_vld  || en4;
    assign en2     = !r_s2_vld  || en3;
    assign en1     = !r_s1_vld  || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_vld <= i_valid;
            end
            if (en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (en3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (en4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (en5) begin
                r_out_vld <= r_s4_vld;
            end
        end
    end

    // ---------------- Stage 1: hue times six, split into sector and f
    logic [HW-1:0] w_h;
    logic [HW+2:0] w_h6;
    logic [15:0]   w_f;

    generate
        if (HW >= 16) begin : g_hue_wide
            assign w_h = HW'(i_data.hue);
            assign w_f = w_h6[HW-1 -: 16];
        end else begin : g_hue_narrow
            // Bits above HUE_BITS drop, so the hue wraps
            assign w_h = i_data.hue[HW-1:0];
            assign w_f = {w_h6[HW-1:0], {(16-HW){1'b0}}};
        end
    endgenerate

    assign w_h6 = {1'b0, w_h, 2'b00} + {2'b00, w_h, 1'b0};

    logic [2:0]  r_s1_sect;
    logic [15:0] r_s1_f;
    logic [7:0]  r_s1_sat, r_s1_val;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_sect <= w_h6[HW+2:HW];
            r_s1_f    <= w_f;
            r_s1_sat  <= i_data.saturation;
            r_s1_val  <= i_data.brightness;
        end
    end

    // ---------------- Stage 2: f*s, (1-f)*s and the p product
    logic [23:0] w_fs;
    logic [24:0] w_cfs;

    assign w_fs  = r_s1_f * r_s1_sat;
    assign w_cfs = (17'h1_0000 - {1'b0, r_s1_f}) * r_s1_sat;

    logic [2:0]  r_s2_sect;
    logic [7:0]  r_s2_val, r_s2_aq, r_s2_at;
    logic [15:0] r_s2_np;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_sect <= r_s1_sect;
            r_s2_val  <= r_s1_val;
            r_s2_aq   <= w_fs[23:16];
            r_s2_at   <= w_cfs[23:16];
            r_s2_np   <= r_s1_val * (hsvrgbw_pkg::C_LEVEL_MAX - r_s1_sat);
        end
    end

    // ---------------- Stage 3: scale q and t by the value
    logic [2:0]  r_s3_sect;
    logic [7:0]  r_s3_val;
    logic [15:0] r_s3_np, r_s3_nq, r_s3_nt;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_sect <= r_s2_sect;
            r_s3_val  <= r_s2_val;
            r_s3_np   <= r_s2_np;
            r_s3_nq   <= r_s2_val * (hsvrgbw_pkg::C_LEVEL_MAX - r_s2_aq);
            r_s3_nt   <= r_s2_val * (hsvrgbw_pkg::C_LEVEL_MAX - r_s2_at);
        end
    end

    // ---------------- Stage 4: divide by 255, then route by sector
    logic [7:0] w_p, w_q, w_t;
    logic [7:0] n_red, n_green, n_blue;

    assign w_p = div255(r_s3_np);
    assign w_q = div255(r_s3_nq);
    assign w_t = div255(r_s3_nt);

    always_comb begin
        unique case (r_s3_sect)
            SECT_RED_YEL: begin
                n_red = r_s3_val; n_green = w_t;      n_blue = w_p;
            end
            SECT_YEL_GRN: begin
                n_red = w_q;      n_green = r_s3_val; n_blue = w_p;
            end
            SECT_GRN_CYN: begin
                n_red = w_p;      n_green = r_s3_val; n_blue = w_t;
            end
            SECT_CYN_BLU: begin
                n_red = w_p;      n_green = w_q;      n_blue = r_s3_val;
            end
            SECT_BLU_MAG: begin
                n_red = w_t;      n_green = w_p;      n_blue = r_s3_val;
            end
            default: begin
                // magenta to red, the last sector
                n_red = r_s3_val; n_green = w_p;      n_blue = w_q;
            end
        endcase
    end

    logic [7:0] r_s4_red, r_s4_green, r_s4_blue;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_red   <= n_red;
            r_s4_green <= n_green;
            r_s4_blue  <= n_blue;
        end
    end

    // ---------------- Stage 5: pull out the common white level when white_mode is on
    logic [7:0] w_min_rg, w_white;
    hsvrgbw_pkg::t_rgbw_word n_out_data, r_out_data;

    assign w_min_rg = (r_s4_red < r_s4_green) ? r_s4_red : r_s4_green;
    assign w_white  = !r_white_mode ? 8'd0 :
                      (w_min_rg < r_s4_blue) ? w_min_rg : r_s4_blue;

    always_comb begin
        n_out_data.red   = r_s4_red   - w_white;
        n_out_data.green = r_s4_green - w_white;
        n_out_data.blue  = r_s4_blue  - w_white;
        n_out_data.white = w_white;
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;

endmodule

/* rtl/hsvrgbw_checker.sv */
module hsvrgbw_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_valid,
    input logic                    i_stall,
    input hsvrgbw_pkg::t_rgbw_word o_data,
    input logic                    i_cfg_we,
    input logic                    i_cfg_wdata
);

    // Mirror of white_mode as seen on the config port
    logic r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid straight after reset");

    a_held_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("held output word changed or dropped");

    a_no_white_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_mode |-> o_data.white == 8'd0)
        else $error("white level set with extraction off");

    a_white_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_mode |->
            (o_data.red == 8'd0 || o_data.green == 8'd0 || o_data.blue == 8'd0))
        else $error("no colour channel at zero after white extraction");

endmodule

bind hsv_to_rgbw_converter_core hsvrgbw_checker u_hsvrgbw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data      (o_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata)
);
